FILE: design/assert_macros.svh
// Assertion helpers for the RTL of the key count table; the table core includes them.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define SKCT_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("skct assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define SKCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skct assertion failed");

`endif

FILE: design/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg: shared types and constants of the sorted key count table
// Default sizes, result status codes and the control and flag structs
// that run between the table controller and the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skct_pkg;

	localparam int MAX_KEYS_DEF   = 64;
	localparam int KEY_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	// Action broadcast to every cell in the update cycle.
	typedef struct packed {
		logic apply;   // update cycle fires
		logic insert;  // new key goes into its sorted place
		logic drop;    // matching entry leaves, later entries move down
		logic bump;    // matching count rises (unless saturated)
		logic dec;     // matching count falls and stays above zero
	} cell_ctrl_t;

	// Compare result that each cell captures when a beat is accepted.
	typedef struct packed {
		logic lt;   // valid and stored key below the incoming key
		logic eq;   // valid and stored key equal to the incoming key
		logic sat;  // eq and count at its maximum
		logic one;  // eq and count equal to one
	} cell_flags_t;

endpackage

`default_nettype wire

FILE: design/sorted_key_count_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_count_table_core: sorted table of keys with occurrence counts
// A row of cells keeps distinct keys in ascending order with a count each;
// add and remove beats update the row and report the new state.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_axis group: tuser carries the opcode (0 adds
//   one occurrence of the key, 1 removes one) and tdata carries the key.
//   Each input beat yields exactly one output beat on the m_axis group with
//   the distinct key total and the key's count in tdata and a status code in
//   tuser (ok, removal of an absent key, table full, count saturated).
//   A beat is accepted in the cycle its compare runs against every cell at
//   once; the apply state then updates the row (shifting entries one place up
//   or down through the neighbor links) and loads the output register, in the
//   cycle after acceptance unless the output register still holds a result
//   the receiver has not taken. s_axis_tready stays low until that update is
//   done, so the block takes no new beat while one is in flight.
//   If the receiver stalls, the result sits in the output register; the
//   block may still accept one more beat, whose update then waits until the
//   output register frees up, and s_axis_tready stays low meanwhile.
//   Reset empties the table at once (the entry total clears; cell contents
//   need no clearing) and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_count_table_core
	import skct_pkg::*;
#(
	parameter int MAX_KEYS   = MAX_KEYS_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int USED_W    = $clog2(MAX_KEYS + 1),
	localparam int IN_W      = ((KEY_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((USED_W + COUNT_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,   // key
	input  wire logic [0:0]       s_axis_tuser,   // opcode
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [OUT_W-1:0] m_axis_tdata,   // distinct_keys, key_count
	output logic      [1:0]       m_axis_tuser    // status
);

	`include "assert_macros.svh"

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_APPLY = 1'b1;

	logic                  state_q;
	logic [USED_W-1:0]     used_q;
	logic [KEY_BITS-1:0]   key_s1;
	logic                  op_s1;
	logic                  out_valid_q;
	logic [USED_W-1:0]     out_used_q;
	logic [COUNT_BITS-1:0] out_cnt_q;
	logic [1:0]            out_st_q;

	logic                  accept;
	logic                  adv;
	logic [KEY_BITS-1:0]   in_key;

	logic [KEY_BITS-1:0]   cell_key [MAX_KEYS];
	logic [COUNT_BITS-1:0] cell_cnt [MAX_KEYS];
	cell_flags_t           cell_flags [MAX_KEYS];
	logic [MAX_KEYS-1:0]   eq_vec;
	logic [MAX_KEYS-1:0]   sat_vec;
	logic [MAX_KEYS-1:0]   one_vec;

	logic                  hit;
	logic                  full;
	logic [COUNT_BITS-1:0] sel_cnt;
	cell_ctrl_t            ctrl;
	logic [USED_W-1:0]     used_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [1:0]            st_d;

	assign in_key        = s_axis_tdata[KEY_BITS-1:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign adv           = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_APPLY;
				ST_APPLY: if (adv) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= in_key;
			op_s1  <= s_axis_tuser[0];
		end
	end

	// The row of cells. Cell 0 sees a "less than" below it so that a key
	// smaller than every stored key lands there; the top cell pulls zeros
	// from above when the row shifts down.
	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic                  prev_lt;
		logic [KEY_BITS-1:0]   prev_key;
		logic [COUNT_BITS-1:0] prev_cnt;
		logic [KEY_BITS-1:0]   next_key;
		logic [COUNT_BITS-1:0] next_cnt;

		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_key = '0;
			assign prev_cnt = '0;
		end else begin : g_mid
			assign prev_lt  = cell_flags[i-1].lt;
			assign prev_key = cell_key[i-1];
			assign prev_cnt = cell_cnt[i-1];
		end

		if (i == MAX_KEYS - 1) begin : g_last
			assign next_key = '0;
			assign next_cnt = '0;
		end else begin : g_low
			assign next_key = cell_key[i+1];
			assign next_cnt = cell_cnt[i+1];
		end

		skct_cell #(
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmp_en   (accept),
			.valid    (used_q > USED_W'(i)),
			.cmp_key  (in_key),
			.ins_key  (key_s1),
			.ctrl     (ctrl),
			.prev_lt  (prev_lt),
			.prev_key (prev_key),
			.prev_cnt (prev_cnt),
			.next_key (next_key),
			.next_cnt (next_cnt),
			.key      (cell_key[i]),
			.cnt      (cell_cnt[i]),
			.flags    (cell_flags[i])
		);

		assign eq_vec[i]  = cell_flags[i].eq;
		assign sat_vec[i] = cell_flags[i].sat;
		assign one_vec[i] = cell_flags[i].one;
	end

	// At most one cell matches, so an AND-OR picks the matching count.
	always_comb begin
		sel_cnt = '0;
		for (int j = 0; j < MAX_KEYS; j++) begin
			sel_cnt = sel_cnt | (cell_cnt[j] & {COUNT_BITS{eq_vec[j]}});
		end
	end

	assign hit  = |eq_vec;
	assign full = (used_q == USED_W'(MAX_KEYS));

	always_comb begin
		ctrl       = '0;
		ctrl.apply = adv;
		used_d     = used_q;
		cnt_d      = '0;
		st_d       = ST_OK;
		if (!op_s1) begin
			if (hit) begin
				ctrl.bump = 1'b1;
				if (|sat_vec) begin
					st_d  = ST_SAT;
					cnt_d = sel_cnt;
				end else begin
					cnt_d = sel_cnt + COUNT_BITS'(1);
				end
			end else if (full) begin
				st_d = ST_FULL;
			end else begin
				ctrl.insert = 1'b1;
				used_d      = used_q + USED_W'(1);
				cnt_d       = COUNT_BITS'(1);
			end
		end else begin
			if (!hit) begin
				st_d = ST_ABSENT;
			end else if (|one_vec) begin
				// Count reaches zero: the entry leaves the row.
				ctrl.drop = 1'b1;
				used_d    = used_q - USED_W'(1);
			end else begin
				ctrl.dec = 1'b1;
				cnt_d    = sel_cnt - COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				used_q      <= used_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_used_q <= used_d;
			out_cnt_q  <= cnt_d;
			out_st_q   <= st_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_cnt_q, out_used_q});
	assign m_axis_tuser  = out_st_q;

	// Stored keys are distinct, so no two cells may match one key.
	`SKCT_ASSERT_ALWAYS(a_eq_onehot, $onehot0(eq_vec))
	// The entry total never passes the row length.
	`SKCT_ASSERT_ALWAYS(a_used_range, used_q <= USED_W'(MAX_KEYS))
	// A key refused by a full table leaves the entry total unchanged.
	`SKCT_ASSERT_NEXT(a_full_keeps, adv && (st_d == ST_FULL), $stable(used_q))
	// No insertion is issued into a full row.
	`SKCT_ASSERT_ALWAYS(a_no_insert_full, !(ctrl.apply && ctrl.insert && full))

endmodule

`default_nettype wire

FILE: design/skct_cell.sv
// ----------------------------------------------------------------------------
// skct_cell: one entry of the sorted key count table
// Holds a key and its count, compares them against the incoming key and
// takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module skct_cell
	import skct_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmp_en,
	input  wire logic                  valid,
	input  wire logic [KEY_BITS-1:0]   cmp_key,
	input  wire logic [KEY_BITS-1:0]   ins_key,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic                  prev_lt,
	input  wire logic [KEY_BITS-1:0]   prev_key,
	input  wire logic [COUNT_BITS-1:0] prev_cnt,
	input  wire logic [KEY_BITS-1:0]   next_key,
	input  wire logic [COUNT_BITS-1:0] next_cnt,
	output logic      [KEY_BITS-1:0]   key,
	output logic      [COUNT_BITS-1:0] cnt,
	output cell_flags_t                flags
);

	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] cnt_q;
	cell_flags_t           flags_q;
	cell_flags_t           flags_d;

	always_comb begin
		flags_d.lt  = valid && (key_q < cmp_key);
		flags_d.eq  = valid && (key_q == cmp_key);
		flags_d.sat = flags_d.eq && (&cnt_q);
		flags_d.one = flags_d.eq && (cnt_q == COUNT_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmp_en) begin
			flags_q <= flags_d;
		end
	end

	// Entries at or above the insertion point take the entry below them;
	// on removal, entries from the matching one upward take the one above.
	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			if (ctrl.insert && !flags_q.lt) begin
				if (prev_lt) begin
					key_q <= ins_key;
					cnt_q <= COUNT_BITS'(1);
				end else begin
					key_q <= prev_key;
					cnt_q <= prev_cnt;
				end
			end else if (ctrl.drop && !flags_q.lt) begin
				key_q <= next_key;
				cnt_q <= next_cnt;
			end else if (ctrl.bump && flags_q.eq && !flags_q.sat) begin
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end else if (ctrl.dec && flags_q.eq) begin
				cnt_q <= cnt_q - COUNT_BITS'(1);
			end
		end
	end

	assign key   = key_q;
	assign cnt   = cnt_q;
	assign flags = flags_q;

endmodule

`default_nettype wire
